[hw/rtl/leb_pkg.sv]
package leb_pkg;

   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int LEN_W    = 10;
   localparam int POS_W    = 11;
   localparam int BYTE_W   = 8;
   localparam int OP_W     = 3;
   localparam int DELTA_W  = 11;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CAPACITY - 1);
   localparam logic [LEN_W-1:0]  FULL_LEN  = LEN_W'(CAPACITY - 1);

   localparam logic [BYTE_W-1:0] KEY_BACKSPACE = 8'h08;
   localparam logic [BYTE_W-1:0] KEY_DELETE    = 8'h7F;
   localparam logic [BYTE_W-1:0] KEY_NEWLINE   = 8'h0A;

   typedef enum logic [OP_W-1:0] {
      OP_KEY   = 3'd0,
      OP_MOVE  = 3'd1,
      OP_CLEAR = 3'd2,
      OP_SAVED = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DEC,
      ST_INS_RD,
      ST_INS_WR,
      ST_INS_KEY,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_READ_WT,
      ST_SCAN_INIT,
      ST_SCAN,
      ST_SCAN_LAST,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic [BYTE_W-1:0]         key_byte;
      logic signed [DELTA_W-1:0] move_delta;
      logic [LEN_W-1:0]          read_index;
   } req_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [BYTE_W-1:0] wdata;
      logic [ADDR_W-1:0] raddr;
   } ram_req_type;

   typedef struct packed {
      logic clr;
      logic en;
   } scan_ctl_type;

   typedef struct packed {
      logic [LEN_W-1:0]  text_length;
      logic [LEN_W-1:0]  cursor_pos;
      logic              dirty_flag;
      logic [BYTE_W-1:0] read_byte;
   } stat_type;

endpackage

[hw/rtl/leb_req_if.sv]
interface leb_req_if;
   logic                              valid;
   logic                              ready;
   logic [leb_pkg::OP_W-1:0]          op;
   logic [leb_pkg::BYTE_W-1:0]        key_byte;
   logic signed [leb_pkg::DELTA_W-1:0] move_delta;
   logic [leb_pkg::LEN_W-1:0]         read_index;

   modport source (output valid, op, key_byte, move_delta, read_index, input ready);
   modport sink (input valid, op, key_byte, move_delta, read_index, output ready);
endinterface

[hw/rtl/leb_rsp_if.sv]
interface leb_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [leb_pkg::LEN_W-1:0]  text_length;
   logic [leb_pkg::LEN_W-1:0]  cursor_pos;
   logic                       dirty_flag;
   logic [leb_pkg::POS_W-1:0]  line_number;
   logic [leb_pkg::POS_W-1:0]  column_number;
   logic [leb_pkg::BYTE_W-1:0] read_byte;

   modport source (output valid, text_length, cursor_pos, dirty_flag, line_number,
                   column_number, read_byte, input ready);
   modport sink (input valid, text_length, cursor_pos, dirty_flag, line_number,
                 column_number, read_byte, output ready);
endinterface

[hw/rtl/line_edit_buffer.sv]
// Each request is decoded, then an insert or delete shifts the text after the cursor byte by
// byte, and line and column are counted by scanning the text before the cursor; valid
// rises in the cycle after the result loads.
// Throughput: one request at a time; ready is low from accept until the result loads.
// Reset: clears length, cursor, dirty flag and lock, then sweeps all 1024 store addresses
// to zero, during which no request is accepted.
module line_edit_buffer (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   leb_req_if.sink     req_ch,
   leb_rsp_if.source   rsp_ch
);
   import leb_pkg::*;

   req_type           req;
   stat_type          stat;
   ram_req_type       ram;
   scan_ctl_type      scan;
   logic [BYTE_W-1:0] ram_rdata;
   logic [POS_W-1:0]  line_number;
   logic [POS_W-1:0]  column_number;
   logic              out_free;
   logic              out_load;

   logic              rsp_vld_ff, rsp_vld_in;
   stat_type          rsp_stat_ff;
   logic [POS_W-1:0]  rsp_line_ff;
   logic [POS_W-1:0]  rsp_col_ff;

   assign req.op         = req_ch.op;
   assign req.key_byte   = req_ch.key_byte;
   assign req.move_delta = req_ch.move_delta;
   assign req.read_index = req_ch.read_index;

   leb_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req         (req),
      .out_free    (out_free),
      .out_load    (out_load),
      .stat        (stat),
      .ram         (ram),
      .ram_rdata   (ram_rdata),
      .scan        (scan)
   );

   leb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock (clock),
      .we    (ram.we),
      .waddr (ram.waddr),
      .wdata (ram.wdata),
      .raddr (ram.raddr),
      .rdata (ram_rdata)
   );

   leb_scan u_scan (
      .clock         (clock),
      .ctl           (scan),
      .data          (ram_rdata),
      .line_number   (line_number),
      .column_number (column_number)
   );

   // hold the result until taken
   assign out_free   = !rsp_vld_ff || rsp_ch.ready;
   assign rsp_vld_in = out_load || (rsp_vld_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_stat_ff <= stat;
         rsp_line_ff <= line_number;
         rsp_col_ff  <= column_number;
      end
   end

   assign rsp_ch.valid         = rsp_vld_ff;
   assign rsp_ch.text_length   = rsp_stat_ff.text_length;
   assign rsp_ch.cursor_pos    = rsp_stat_ff.cursor_pos;
   assign rsp_ch.dirty_flag    = rsp_stat_ff.dirty_flag;
   assign rsp_ch.line_number   = rsp_line_ff;
   assign rsp_ch.column_number = rsp_col_ff;
   assign rsp_ch.read_byte     = rsp_stat_ff.read_byte;

endmodule

[hw/rtl/leb_ram.sv]
module leb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/leb_scan.sv]
module leb_scan (
   input  logic                       clock,
   input  leb_pkg::scan_ctl_type      ctl,
   input  logic [leb_pkg::BYTE_W-1:0] data,
   output logic [leb_pkg::POS_W-1:0]  line_number,
   output logic [leb_pkg::POS_W-1:0]  column_number
);
   import leb_pkg::*;

   logic [POS_W-1:0] line_ff, line_in;
   logic [POS_W-1:0] col_ff, col_in;

   always_comb begin
      line_in = line_ff;
      col_in  = col_ff;
      if (ctl.clr) begin
         line_in = POS_W'(1);
         col_in  = POS_W'(1);
      end else if (ctl.en) begin
         if (data == KEY_NEWLINE) begin
            line_in = line_ff + POS_W'(1);
            col_in  = POS_W'(1);
         end else begin
            col_in = col_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      line_ff <= line_in;
      col_ff  <= col_in;
   end

   assign line_number   = line_ff;
   assign column_number = col_ff;

endmodule

[hw/rtl/leb_seq.sv]
module leb_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic                       csr_wr_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  leb_pkg::req_type           req,
   input  logic                       out_free,
   output logic                       out_load,
   output leb_pkg::stat_type          stat,
   output leb_pkg::ram_req_type       ram,
   input  logic [leb_pkg::BYTE_W-1:0] ram_rdata,
   output leb_pkg::scan_ctl_type      scan
);
   import leb_pkg::*;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [LEN_W-1:0]  cursor_ff, cursor_in;
   logic [LEN_W-1:0]  length_ff, length_in;
   logic              dirty_ff, dirty_in;
   logic              lock_ff, lock_in;
   logic [BYTE_W-1:0] rbyte_ff, rbyte_in;
   logic              cnt_en_ff, cnt_en_in;

   logic                    is_del;
   logic                    del_ok;
   logic                    ins_ok;
   logic                    accept;
   logic signed [LEN_W+1:0] move_sum;
   logic [LEN_W-1:0]        move_pos;

   assign accept = req_valid && req_ready;
   assign is_del = (req_ff.key_byte == KEY_BACKSPACE) || (req_ff.key_byte == KEY_DELETE);
   assign del_ok = !lock_ff && (cursor_ff != '0);
   assign ins_ok = length_ff < FULL_LEN;

   // clamp the moved cursor to the text
   assign move_sum = $signed({2'b00, cursor_ff})
                   + $signed({req_ff.move_delta[DELTA_W-1], req_ff.move_delta});

   always_comb begin
      if (move_sum[LEN_W+1]) begin
         move_pos = '0;
      end else if (move_sum[LEN_W:0] > {1'b0, length_ff}) begin
         move_pos = length_ff;
      end else begin
         move_pos = move_sum[LEN_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (ptr_ff == LAST_ADDR) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_DEC;
         end
         ST_DEC: begin
            case (req_ff.op)
               OP_KEY: begin
                  if (is_del) begin
                     state_in = del_ok ? ST_DEL_RD : ST_SCAN_INIT;
                  end else begin
                     state_in = ins_ok ? ST_INS_RD : ST_SCAN_INIT;
                  end
               end
               OP_READ: state_in = ST_READ_WT;
               default: state_in = ST_SCAN_INIT;
            endcase
         end
         ST_INS_RD:  state_in = ST_INS_WR;
         ST_INS_WR: begin
            state_in = (ptr_ff == cursor_ff) ? ST_INS_KEY : ST_INS_RD;
         end
         ST_INS_KEY: state_in = ST_SCAN_INIT;
         ST_DEL_RD:  state_in = ST_DEL_WR;
         ST_DEL_WR: begin
            state_in = (ptr_ff == length_ff) ? ST_SCAN_INIT : ST_DEL_RD;
         end
         ST_READ_WT: state_in = ST_SCAN_INIT;
         ST_SCAN_INIT: begin
            state_in = (cursor_ff == '0) ? ST_DONE : ST_SCAN;
         end
         ST_SCAN: begin
            if (ptr_ff == cursor_ff - LEN_W'(1)) state_in = ST_SCAN_LAST;
         end
         ST_SCAN_LAST: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      ram       = '0;
      scan.clr  = 1'b0;
      scan.en   = cnt_en_ff;
      req_ready = (state_ff == ST_IDLE);
      out_load  = (state_ff == ST_DONE) && out_free;
      cnt_en_in = (state_ff == ST_SCAN);
      case (state_ff)
         ST_CLEAR: begin
            ram.we    = 1'b1;
            ram.waddr = ptr_ff;
         end
         ST_DEC: begin
            if (req_ff.op == OP_CLEAR) begin
               ram.we = 1'b1;
            end
            ram.raddr = req_ff.read_index;
         end
         ST_INS_RD: ram.raddr = ptr_ff;
         ST_INS_WR: begin
            ram.we    = 1'b1;
            ram.waddr = ptr_ff + ADDR_W'(1);
            ram.wdata = ram_rdata;
         end
         ST_INS_KEY: begin
            ram.we    = 1'b1;
            ram.waddr = cursor_ff;
            ram.wdata = req_ff.key_byte;
         end
         ST_DEL_RD: ram.raddr = ptr_ff;
         ST_DEL_WR: begin
            ram.we    = 1'b1;
            ram.waddr = ptr_ff - ADDR_W'(1);
            ram.wdata = ram_rdata;
         end
         ST_SCAN_INIT: scan.clr = 1'b1;
         ST_SCAN: ram.raddr = ptr_ff;
         default: ram = '0;
      endcase
   end

   // datapath registers
   always_comb begin
      req_in    = req_ff;
      ptr_in    = ptr_ff;
      cursor_in = cursor_ff;
      length_in = length_ff;
      dirty_in  = dirty_ff;
      rbyte_in  = rbyte_ff;
      lock_in   = csr_wr_en ? csr_wr_data : lock_ff;
      case (state_ff)
         ST_CLEAR: ptr_in = ptr_ff + ADDR_W'(1);
         ST_IDLE: begin
            if (accept) req_in = req;
         end
         ST_DEC: begin
            rbyte_in = '0;
            case (req_ff.op)
               OP_KEY: ptr_in = is_del ? cursor_ff : length_ff;
               OP_MOVE: cursor_in = move_pos;
               OP_CLEAR: begin
                  cursor_in = '0;
                  length_in = '0;
                  dirty_in  = 1'b0;
               end
               OP_SAVED: dirty_in = 1'b0;
               default: ptr_in = ptr_ff;
            endcase
         end
         ST_INS_WR: ptr_in = ptr_ff - ADDR_W'(1);
         ST_INS_KEY: begin
            cursor_in = cursor_ff + LEN_W'(1);
            length_in = length_ff + LEN_W'(1);
            dirty_in  = 1'b1;
         end
         ST_DEL_WR: begin
            ptr_in = ptr_ff + ADDR_W'(1);
            if (ptr_ff == length_ff) begin
               cursor_in = cursor_ff - LEN_W'(1);
               length_in = length_ff - LEN_W'(1);
               dirty_in  = 1'b1;
            end
         end
         ST_READ_WT: rbyte_in = ram_rdata;
         ST_SCAN_INIT: ptr_in = '0;
         ST_SCAN: ptr_in = ptr_ff + ADDR_W'(1);
         default: ptr_in = ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         ptr_ff    <= '0;
         cursor_ff <= '0;
         length_ff <= '0;
         dirty_ff  <= 1'b0;
         lock_ff   <= 1'b0;
         cnt_en_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ptr_ff    <= ptr_in;
         cursor_ff <= cursor_in;
         length_ff <= length_in;
         dirty_ff  <= dirty_in;
         lock_ff   <= lock_in;
         cnt_en_ff <= cnt_en_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rbyte_ff <= rbyte_in;
   end

   assign stat.text_length = length_ff;
   assign stat.cursor_pos  = cursor_ff;
   assign stat.dirty_flag  = dirty_ff;
   assign stat.read_byte   = rbyte_ff;

   a_cursor_in_text: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= length_ff)
      else $error("cursor beyond text length");

   a_room_for_tail: assert property (@(posedge clock) disable iff (reset)
      length_ff < FULL_LEN || (state_ff == ST_IDLE && $stable(length_ff)) ||
      state_ff != ST_INS_KEY)
      else $error("insert on a full buffer");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_DONE) |-> !ram.we)
      else $error("store written while no request is in progress");

   a_load_then_idle: assert property (@(posedge clock) disable iff (reset)
      out_load |=> state_ff == ST_IDLE)
      else $error("result loaded without returning to idle");

endmodule
